[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the deque project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active (rst is active low).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/cdq_pkg.sv]
// ---------------------------------------------------------------------------
// cdq_pkg
// Shared codes and field widths of the circular deque.
// ---------------------------------------------------------------------------
package cdq_pkg;

  // Field widths
  localparam int ACT_W  = 3;
  localparam int KIND_W = 2;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 7;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COUNT      = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COUNT = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

[hdl/cdq_ring_ram.sv]
// ---------------------------------------------------------------------------
// cdq_ring_ram
// Ring storage: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module cdq_ring_ram
  import cdq_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  data_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output data_t         rdata
);

  data_t mem [DEPTH];
  data_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/circular_deque_unit.sv]
// ---------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue kept in a ring memory, streaming command/result ports.
// ---------------------------------------------------------------------------
// One item is taken at a time. An item is accepted in IDLE, then EXEC
// updates the ring pointers (and writes a pushed value); a push or a pop
// that leaves entries then streams the deque contents front to back at one
// result per cycle, unless output back-pressure holds it, out of the ring
// memory's single read port, through a registered read stage, and returns
// to idle. A count query, an empty marker, a dropped push or an unknown
// action returns to idle straight from EXEC. The last result of an item
// may still wait in the output register while the next item is taken. A
// capacity write empties the deque but keeps the stored values; no clearing
// pass is needed after reset.
// ---------------------------------------------------------------------------
module circular_deque_unit
  import cdq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  data_t             in_tdata,   // [31:0] value
  input  logic [ACT_W-1:0]  in_tuser,   // [2:0] action
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output data_t             out_tdata,  // [31:0] data
  output logic [KIND_W-1:0] out_tuser,  // [1:0] kind
  output logic              out_tlast,
  // capacity register
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r, cap_eff;
  logic [IDX_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [ACT_W-1:0]  act_r;
  data_t             val_r;
  logic [IDX_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              p1_v_r, p1_v_nxt, p1_last_r, p1_last_nxt;
  logic              out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  data_t             out_data_r, out_data_nxt;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  data_t             ram_rdata;

  logic              out_free, move, issue, full;

  // effective capacity: zero acts as one, clipped to the ring depth
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_r > CAP_W'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  assign full      = CAP_W'(occ_r) >= cap_eff;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // ring storage
  cdq_ring_ram #(
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // Control: pointer update in EXEC, read streaming in EMIT. The write in
  // EXEC always lands before the first read of the same item, and no reads
  // are in flight during EXEC, so no forwarding is needed.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    rd_ptr_nxt    = rd_ptr_r;
    left_nxt      = left_r;
    p1_v_nxt      = p1_v_r;
    p1_last_nxt   = p1_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_re        = 1'b0;
    move          = 1'b0;
    issue         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (act_r)
          ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (full) begin
              state_nxt = ST_IDLE;  // dropped
            end else begin
              if (occ_r == '0) begin
                head_nxt  = '0;
                tail_nxt  = '0;
                ram_waddr = '0;
              end else if (act_r == ACT_PUSH_FRONT) begin
                head_nxt  = (head_r == '0) ? IDX_W'(cap_eff - CAP_W'(1))
                                           : head_r - IDX_W'(1);
                ram_waddr = head_nxt;
              end else begin
                tail_nxt  = (CAP_W'(tail_r) + CAP_W'(1) == cap_eff) ? '0
                                                                   : tail_r + IDX_W'(1);
                ram_waddr = tail_nxt;
              end
              ram_we     = 1'b1;
              occ_nxt    = occ_r + CNT_W'(1);
              rd_ptr_nxt = head_nxt;
              left_nxt   = occ_r + CNT_W'(1);
              state_nxt  = ST_EMIT;
            end
          end

          ACT_POP_FRONT, ACT_POP_BACK: begin
            if (occ_r <= CNT_W'(1)) begin
              // empty before or after: a single empty marker
              if (out_free) begin
                head_nxt      = '0;
                tail_nxt      = '0;
                occ_nxt       = '0;
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_EMPTY;
                out_data_nxt  = '0;
                out_last_nxt  = 1'b1;
                state_nxt     = ST_IDLE;
              end
            end else begin
              if (act_r == ACT_POP_FRONT) begin
                head_nxt = (CAP_W'(head_r) + CAP_W'(1) == cap_eff) ? '0
                                                                   : head_r + IDX_W'(1);
              end else begin
                tail_nxt = (tail_r == '0) ? IDX_W'(cap_eff - CAP_W'(1))
                                          : tail_r - IDX_W'(1);
              end
              occ_nxt    = occ_r - CNT_W'(1);
              rd_ptr_nxt = head_nxt;
              left_nxt   = occ_r - CNT_W'(1);
              state_nxt  = ST_EMIT;
            end
          end

          ACT_COUNT: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_COUNT;
              out_data_nxt  = DATA_W'(occ_r);
              out_last_nxt  = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end

          default: begin
            state_nxt = ST_IDLE;  // unknown action, no effect
          end
        endcase
      end

      ST_EMIT: begin
        // read data stage into the output register
        move = p1_v_r && out_free;
        if (move) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ELEM;
          out_data_nxt  = ram_rdata;
          out_last_nxt  = p1_last_r;
        end
        // next read while the data stage is free or emptying
        issue = (left_r != '0) && (!p1_v_r || move);
        if (issue) begin
          ram_re      = 1'b1;
          p1_v_nxt    = 1'b1;
          p1_last_nxt = (left_r == CNT_W'(1));
          left_nxt    = left_r - CNT_W'(1);
          rd_ptr_nxt  = (CAP_W'(rd_ptr_r) + CAP_W'(1) == cap_eff) ? '0
                                                                 : rd_ptr_r + IDX_W'(1);
        end else if (move) begin
          p1_v_nxt = 1'b0;
        end
        if (left_r == '0 && !p1_v_r) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      left_r      <= '0;
      p1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      p1_v_r      <= p1_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        // capacity write empties the deque
        cap_r  <= cfg_data;
        head_r <= '0;
        tail_r <= '0;
        occ_r  <= '0;
      end else begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        occ_r  <= occ_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r <= in_tuser;
      val_r <= in_tdata;
    end
    rd_ptr_r   <= rd_ptr_nxt;
    p1_last_r  <= p1_last_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

[hdl/cdq_port_checker.sv]
// ---------------------------------------------------------------------------
// cdq_port_checker
// Port-level checks of the circular deque, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cdq_port_checker
  import cdq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input data_t             out_tdata,  // [31:0] data
  input logic [KIND_W-1:0] out_tuser,  // [1:0] kind
  input logic              out_tlast
);

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")

  // only the three result kinds appear
  `ASSERT_CLK(a_kind_legal, clk, rst_n, out_tvalid |-> (out_tuser == KIND_ELEM || out_tuser == KIND_EMPTY || out_tuser == KIND_COUNT), "illegal result kind")

  // empty marker is a single zero result
  `ASSERT_CLK(a_empty_form, clk, rst_n, out_tvalid && out_tuser == KIND_EMPTY |-> out_tlast && out_tdata == '0, "malformed empty marker")

  // count is a single result within the ring depth
  `ASSERT_CLK(a_count_form, clk, rst_n, out_tvalid && out_tuser == KIND_COUNT |-> out_tlast && $unsigned(out_tdata) <= DEPTH, "malformed count result")

endmodule

bind circular_deque_unit cdq_port_checker #(.DEPTH(DEPTH)) u_port_checker (.*);

[bench/deque_contents_checker.sv]
// ---------------------------------------------------------------------------
// deque_contents_checker
// Watches the command, result and capacity channels of the circular deque,
// tracks the deque's contents itself and compares every result item.
// ---------------------------------------------------------------------------
module deque_contents_checker
  import cdq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  data_t             in_tdata,   // [31:0] value
  input  logic [ACT_W-1:0]  in_tuser,   // [2:0] action
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  data_t             out_tdata,  // [31:0] data
  input  logic [KIND_W-1:0] out_tuser,  // [1:0] kind
  input  logic              out_tlast,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data,
  output int unsigned       fail_count,
  output int unsigned       outstanding,
  output int unsigned       results_seen,
  output int unsigned       full_drops
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;
    logic              last;
  } deque_result_t;

  // Result items still owed by the block, oldest first
  deque_result_t     owed_results[$];

  // Own copy of the deque
  logic [DATA_W-1:0] ring_copy [DEPTH];
  int unsigned       front_idx;
  int unsigned       back_idx;
  int unsigned       fill;
  logic [CAP_W-1:0]  cap_setting;

  // Capacity as the ring actually uses it: 0 acts as 1, above DEPTH as DEPTH
  function automatic int unsigned usable_slots();
    int unsigned c;
    c = cap_setting;
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 20) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic owe_result(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] data,
                            input logic last);
    deque_result_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    owed_results.insert(owed_results.size(), r);
  endtask

  // Whole contents front to back, or one empty marker
  task automatic owe_contents();
    int unsigned c;
    c = usable_slots();
    if (fill == 0) begin
      owe_result(KIND_EMPTY, '0, 1'b1);
    end else begin
      for (int unsigned i = 0; i < fill; i++)
        owe_result(KIND_ELEM, ring_copy[(front_idx + i) % c], (i + 1 == fill));
    end
  endtask

  // Apply one accepted command to the copy and queue what it must produce
  task automatic predict_deque_op(input logic [ACT_W-1:0] act, input data_t val);
    int unsigned c;
    c = usable_slots();
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (fill >= c) begin
          full_drops++;   // full: dropped silently
        end else begin
          if (fill == 0) begin
            front_idx = 0;
            back_idx  = 0;
            ring_copy[0] = val;
          end else if (act == ACT_PUSH_FRONT) begin
            front_idx = (front_idx + c - 1) % c;
            ring_copy[front_idx] = val;
          end else begin
            back_idx = (back_idx + 1) % c;
            ring_copy[back_idx] = val;
          end
          fill++;
          owe_contents();
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (fill == 0) begin
          owe_result(KIND_EMPTY, '0, 1'b1);
        end else begin
          if (fill == 1) begin
            front_idx = 0;
            back_idx  = 0;
          end else if (act == ACT_POP_FRONT) begin
            front_idx = (front_idx + 1) % c;
          end else begin
            back_idx = (back_idx + c - 1) % c;
          end
          fill--;
          owe_contents();
        end
      end
      ACT_COUNT: owe_result(KIND_COUNT, DATA_W'(fill), 1'b1);
      default: ;  // unknown action codes do nothing
    endcase
  endtask

  always @(posedge clk) begin : watch
    deque_result_t exp_r;
    if (!rst_n) begin
      owed_results.delete();
      front_idx   = 0;
      back_idx    = 0;
      fill        = 0;
      cap_setting = CAP_RESET;
    end else begin
      // results first: they always belong to earlier commands
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d data %h last %b",
                                    out_tuser, out_tdata, out_tlast));
        end else begin
          exp_r = owed_results[0];
          owed_results.delete(0);
          if (out_tuser !== exp_r.kind || out_tdata !== exp_r.data ||
              out_tlast !== exp_r.last)
            report_mismatch($sformatf(
              "got kind %0d data %h last %b, expected kind %0d data %h last %b",
              out_tuser, out_tdata, out_tlast, exp_r.kind, exp_r.data, exp_r.last));
        end
      end
      // capacity write empties the deque, stored values stay
      if (cfg_valid && cfg_ready) begin
        cap_setting = cfg_data;
        front_idx   = 0;
        back_idx    = 0;
        fill        = 0;
      end
      if (in_tvalid && in_tready) predict_deque_op(in_tuser, in_tdata);
    end
    outstanding <= owed_results.size();
  end

endmodule

[bench/circular_deque_unit_tb.sv]
// ---------------------------------------------------------------------------
// circular_deque_unit_tb
// Drives commands and capacity writes into the circular deque under random
// idling on both channels; a separate checker predicts and compares results.
// ---------------------------------------------------------------------------
module circular_deque_unit_tb
  import cdq_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES  = 8;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  data_t             in_tdata;   // [31:0] value
  logic [ACT_W-1:0]  in_tuser;   // [2:0] action
  logic              out_tvalid;
  logic              out_tready;
  data_t             out_tdata;  // [31:0] data
  logic [KIND_W-1:0] out_tuser;  // [1:0] kind
  logic              out_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_data;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned full_drops;

  int unsigned commands_sent;
  int unsigned cap_writes;
  int unsigned quiet_cycles;
  bit          tx_steady;
  bit          rx_steady;
  int unsigned rx_hold_req;

  circular_deque_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  deque_contents_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .full_drops   (full_drops)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic data_t pick_value();
    if ($urandom_range(0, 9) != 0) return data_t'($urandom());
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Result side: random stalls, plus one long hold on request
  initial begin : receiver
    int unsigned stall_left;
    int unsigned hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != hold_seen) begin
        hold_seen  = rx_hold_req;
        stall_left = RX_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (rx_steady || $urandom_range(0, 99) < 60) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = gap_len();
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Watchdog: ends a run that stops moving
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results still owed",
               quiet_cycles, outstanding);
      $display("circular_deque_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One command item; valid stays high when the next item follows at once
  task automatic send_cmd(input logic [ACT_W-1:0] act, input data_t val);
    int unsigned gap;
    gap = tx_steady ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    commands_sent++;
  endtask

  // Let every owed result drain, then let a dropped push settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  task automatic run_random(input int unsigned n, input int unsigned push_pct);
    logic [ACT_W-1:0] act;
    int unsigned      r;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < push_pct) begin
        act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 72)      act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
        else if (r < 88) act = ACT_COUNT;
        else             act = ACT_W'($urandom_range(5, 7));  // unused codes
      end
      send_cmd(act, pick_value());
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tuser      <= ACT_COUNT;
    cfg_valid     <= 1'b0;
    cfg_data      <= CAP_RESET;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    rx_hold_req   = 0;
    commands_sent = 0;
    cap_writes    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pops, count, unused codes, extreme values at both ends
    send_cmd(ACT_POP_FRONT, pick_value());
    send_cmd(ACT_POP_BACK, pick_value());
    send_cmd(ACT_COUNT, pick_value());
    send_cmd(ACT_W'(5), pick_value());
    send_cmd(ACT_W'(6), pick_value());
    send_cmd(ACT_W'(7), pick_value());
    send_cmd(ACT_PUSH_FRONT, 32'sh8000_0000);
    send_cmd(ACT_PUSH_BACK, 32'sh7fff_ffff);
    send_cmd(ACT_PUSH_FRONT, '0);
    send_cmd(ACT_PUSH_BACK, '1);
    send_cmd(ACT_COUNT, '0);
    send_cmd(ACT_POP_FRONT, '0);
    send_cmd(ACT_POP_BACK, '0);
    send_cmd(ACT_PUSH_BACK, 32'sh1234_5678);
    send_cmd(ACT_POP_BACK, '0);
    send_cmd(ACT_POP_FRONT, '0);
    send_cmd(ACT_POP_FRONT, '0);
    send_cmd(ACT_POP_BACK, '0);

    // Capacity 0 acts as one slot: second and third pushes are dropped, refill after empty
    write_capacity('0);
    send_cmd(ACT_PUSH_BACK, pick_value());
    send_cmd(ACT_PUSH_FRONT, pick_value());
    send_cmd(ACT_PUSH_BACK, pick_value());
    send_cmd(ACT_COUNT, '0);
    send_cmd(ACT_POP_FRONT, '0);
    send_cmd(ACT_PUSH_FRONT, pick_value());
    send_cmd(ACT_POP_BACK, '0);

    // Random phases over several capacities, wrap-around on small rings
    write_capacity(7'd2);
    run_random(16, 55);
    write_capacity(7'd127);   // clamps to the full ring
    run_random(16, 60);
    write_capacity(7'd5);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_random(14, 50);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    write_capacity(CAP_W'($urandom_range(0, 127)));
    run_random(14, 55);

    // Back-pressure: results held off while commands keep coming
    write_capacity(7'd8);
    rx_hold_req++;
    tx_steady     = 1'b1;
    run_random(12, 85);
    tx_steady     = 1'b0;

    write_capacity(7'd64);
    run_random(14, 50);

    wait_idle();
    repeat (20) @(posedge clk);

    $display("Run covered %0d commands under %0d capacity writes.", commands_sent, cap_writes);
    $display("%0d results compared, %0d pushes dropped on a full deque, %0d failures.",
             results_seen, full_drops, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("circular_deque_unit_tb OK");
    end else begin
      $display("circular_deque_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
